>>> rtl/ptfa_pkg.sv
// shared types, codes and sizing constants for the partition table fit allocator
// no dependencies; every other rtl file refers to it by scoped names
package ptfa_pkg;

	// defaults for the top-level parameters
	localparam int DEF_TABLE_SLOTS  = 4;
	localparam int DEF_ADDRESS_BITS = 48;

	// fixed field widths
	localparam int DISK_SIZE_W    = 48;
	localparam int FIRST_USABLE_W = 16;
	localparam int NAME_W         = 64;
	localparam int AMOUNT_W       = 32;
	localparam int APB_DATA_W     = 64;
	localparam int APB_ADDR_W     = 4;

	// a 32-bit magnitude (at most 2^31) scaled by up to 2^20
	localparam int KIB_SHIFT = 10;
	localparam int MIB_SHIFT = 20;
	localparam int DELTA_W   = AMOUNT_W + MIB_SHIFT;

	// register select taken from paddr bit 3 (registers sit 8 bytes apart)
	localparam logic REG_DISK_SIZE    = 1'b0;
	localparam logic REG_FIRST_USABLE = 1'b1;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_RESIZE = 2'd2
	} kind_e;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_e;

	typedef enum logic [1:0] {
		UNIT_BYTES = 2'd0,
		UNIT_KIB   = 2'd1,
		UNIT_MIB   = 2'd2
	} unit_e;

	typedef enum logic [3:0] {
		ST_OK         = 4'd0,
		ST_BAD_SIZE   = 4'd1,
		ST_EXT_EXISTS = 4'd2,
		ST_FULL       = 4'd3,
		ST_DUP        = 4'd4,
		ST_NO_SPACE   = 4'd5,
		ST_NOT_FOUND  = 4'd6,
		ST_MOUNTED    = 4'd7,
		ST_SHRINK     = 4'd8,
		ST_NO_ROOM    = 4'd9
	} status_t;

	// table update for one request, at most one bit set
	typedef struct packed {
		logic create;
		logic remove;
		logic resize;
	} tbl_op_t;

	// bits needed to index n things, never below one
	function automatic int idx_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

>>> rtl/ptfa_cfg.sv
// apb register block holding disk size and first usable byte
// depends on ptfa_pkg
module ptfa_cfg #(
	parameter int ADDRESS_BITS = ptfa_pkg::DEF_ADDRESS_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ptfa_pkg::APB_ADDR_W-1:0]       paddr,
	input  logic [ptfa_pkg::APB_DATA_W-1:0]       pwdata,
	output logic [ptfa_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                  pready,
	output logic [ADDRESS_BITS-1:0]               disk_size,
	output logic [ptfa_pkg::FIRST_USABLE_W-1:0]   first_usable
);

	logic [ADDRESS_BITS-1:0]             disk_q;
	logic [ptfa_pkg::FIRST_USABLE_W-1:0] first_q;
	logic                                wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q  <= '0;
			first_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3])
				ptfa_pkg::REG_DISK_SIZE: begin
					disk_q <= ADDRESS_BITS'(pwdata[ptfa_pkg::DISK_SIZE_W-1:0]);
				end
				ptfa_pkg::REG_FIRST_USABLE: begin
					first_q <= pwdata[ptfa_pkg::FIRST_USABLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			ptfa_pkg::REG_DISK_SIZE:    prdata = ptfa_pkg::APB_DATA_W'(disk_q);
			ptfa_pkg::REG_FIRST_USABLE: prdata = ptfa_pkg::APB_DATA_W'(first_q);
			default:                    prdata = '0;
		endcase
	end

	assign disk_size    = disk_q;
	assign first_usable = first_q;

endmodule

>>> rtl/ptfa_table.sv
// partition entry registers with create, delete and resize updates
// depends on ptfa_pkg
module ptfa_table #(
	parameter int TABLE_SLOTS  = ptfa_pkg::DEF_TABLE_SLOTS,
	parameter int ADDRESS_BITS = ptfa_pkg::DEF_ADDRESS_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  ptfa_pkg::tbl_op_t                         op,
	input  logic [ptfa_pkg::idx_w(TABLE_SLOTS)-1:0]   wr_slot,
	input  logic                                      wr_ext,
	input  logic [ADDRESS_BITS-1:0]                   wr_start,
	input  logic [ADDRESS_BITS-1:0]                   wr_size,
	input  logic [ptfa_pkg::NAME_W-1:0]               wr_name,
	output logic [TABLE_SLOTS-1:0]                    valid,
	output logic [TABLE_SLOTS-1:0]                    ext,
	output logic [ADDRESS_BITS-1:0]                   start [TABLE_SLOTS],
	output logic [ADDRESS_BITS-1:0]                   size [TABLE_SLOTS],
	output logic [ptfa_pkg::NAME_W-1:0]               name [TABLE_SLOTS]
);

	localparam int SW = ptfa_pkg::idx_w(TABLE_SLOTS);

	logic [TABLE_SLOTS-1:0]          valid_q;
	logic [TABLE_SLOTS-1:0]          ext_q;
	logic [ADDRESS_BITS-1:0]         start_q [TABLE_SLOTS];
	logic [ADDRESS_BITS-1:0]         size_q [TABLE_SLOTS];
	logic [ptfa_pkg::NAME_W-1:0]     name_q [TABLE_SLOTS];

	// flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ext_q   <= '0;
		end else begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (wr_slot == SW'(i)) begin
					if (op.create) begin
						valid_q[i] <= 1'b1;
						ext_q[i]   <= wr_ext;
					end else if (op.remove) begin
						valid_q[i] <= 1'b0;
						ext_q[i]   <= 1'b0;
					end
				end
			end
		end
	end

	// payload, only read behind a valid bit
	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (wr_slot == SW'(i)) begin
				if (op.create) begin
					start_q[i] <= wr_start;
					size_q[i]  <= wr_size;
					name_q[i]  <= wr_name;
				end else if (op.resize) begin
					size_q[i] <= wr_size;
				end
			end
		end
	end

	assign valid = valid_q;
	assign ext   = ext_q;
	assign start = start_q;
	assign size  = size_q;
	assign name  = name_q;

endmodule

>>> rtl/ptfa_fit.sv
// free gap finder and first / best / worst fit selection over the table
// depends on ptfa_pkg
module ptfa_fit #(
	parameter int TABLE_SLOTS  = ptfa_pkg::DEF_TABLE_SLOTS,
	parameter int ADDRESS_BITS = ptfa_pkg::DEF_ADDRESS_BITS
) (
	input  logic [TABLE_SLOTS-1:0]                  valid,
	input  logic [ADDRESS_BITS-1:0]                 start [TABLE_SLOTS],
	input  logic [ADDRESS_BITS-1:0]                 size [TABLE_SLOTS],
	input  logic [ADDRESS_BITS-1:0]                 disk_size,
	input  logic [ptfa_pkg::FIRST_USABLE_W-1:0]     first_usable,
	input  logic [ADDRESS_BITS-1:0]                 need,
	input  logic [1:0]                              fit_mode,
	output logic                                    found,
	output logic [ADDRESS_BITS-1:0]                 pick_start
);

	localparam int AW = ADDRESS_BITS;
	localparam int EW = ADDRESS_BITS + 1;
	localparam int NG = TABLE_SLOTS + 1;
	localparam int RW = ptfa_pkg::idx_w(TABLE_SLOTS + 1);

	logic [EW-1:0] ent_end [TABLE_SLOTS];
	logic [RW-1:0] rank [TABLE_SLOTS];
	logic [RW-1:0] used;
	logic [EW-1:0] cur [NG];
	logic [EW-1:0] fu_ext;
	logic [EW-1:0] disk_ext;
	logic [NG-1:0] gap_ok;
	logic [NG-1:0] elig;
	logic [NG-1:0] win;
	logic [AW-1:0] gap_st [NG];
	logic [AW-1:0] gap_sz [NG];
	logic [RW-1:0] key [NG];

	assign fu_ext   = EW'(first_usable);
	assign disk_ext = EW'(disk_size);

	// address order of the live entries, equal starts broken by slot
	always_comb begin
		used = '0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			ent_end[i] = EW'(start[i]) + EW'(size[i]);
			rank[i]    = '0;
			for (int j = 0; j < TABLE_SLOTS; j++) begin
				if (j != i && valid[j] &&
				    (start[j] < start[i] || (start[j] == start[i] && j < i))) begin
					rank[i] = rank[i] + RW'(1);
				end
			end
			if (valid[i]) begin
				used = used + RW'(1);
			end
		end
	end

	// walk position before each entry: end of its predecessor in order, first_usable for the first
	always_comb begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			cur[i] = fu_ext;
			if (rank[i] != '0) begin
				cur[i] = '0;
				for (int j = 0; j < TABLE_SLOTS; j++) begin
					if (valid[j] && rank[j] == rank[i] - RW'(1)) begin
						cur[i] = cur[i] | ent_end[j];
					end
				end
			end
		end
		cur[TABLE_SLOTS] = fu_ext;
		if (used != '0) begin
			cur[TABLE_SLOTS] = '0;
			for (int j = 0; j < TABLE_SLOTS; j++) begin
				if (valid[j] && rank[j] == used - RW'(1)) begin
					cur[TABLE_SLOTS] = cur[TABLE_SLOTS] | ent_end[j];
				end
			end
		end
	end

	// gap before each entry, then the tail gap up to the disk end
	always_comb begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			gap_ok[i] = valid[i] && (EW'(start[i]) > cur[i]);
			gap_st[i] = cur[i][AW-1:0];
			gap_sz[i] = AW'(EW'(start[i]) - cur[i]);
			key[i]    = rank[i];
		end
		gap_ok[TABLE_SLOTS] = cur[TABLE_SLOTS] < disk_ext;
		gap_st[TABLE_SLOTS] = cur[TABLE_SLOTS][AW-1:0];
		gap_sz[TABLE_SLOTS] = AW'(disk_ext - cur[TABLE_SLOTS]);
		key[TABLE_SLOTS]    = used;
		for (int g = 0; g < NG; g++) begin
			elig[g] = gap_ok[g] && (gap_sz[g] >= need);
		end
	end

	// pairwise contest, earlier gap wins a tie
	always_comb begin
		for (int c = 0; c < NG; c++) begin
			win[c] = elig[c];
			for (int d = 0; d < NG; d++) begin
				if (d != c && elig[d]) begin
					case (fit_mode)
						ptfa_pkg::FIT_FIRST: begin
							win[c] = win[c] && (key[c] < key[d]);
						end
						ptfa_pkg::FIT_BEST: begin
							win[c] = win[c] && ((gap_sz[c] < gap_sz[d]) ||
							         (gap_sz[c] == gap_sz[d] && key[c] < key[d]));
						end
						default: begin
							win[c] = win[c] && ((gap_sz[c] > gap_sz[d]) ||
							         (gap_sz[c] == gap_sz[d] && key[c] < key[d]));
						end
					endcase
				end
			end
		end
		pick_start = '0;
		for (int c = 0; c < NG; c++) begin
			if (win[c]) begin
				pick_start = pick_start | gap_st[c];
			end
		end
		found = |win;
	end

endmodule

>>> rtl/ptfa_exec.sv
// request evaluation: checks, name lookup, resize bound, result and table update
// depends on ptfa_pkg and ptfa_fit
module ptfa_exec #(
	parameter int TABLE_SLOTS  = ptfa_pkg::DEF_TABLE_SLOTS,
	parameter int ADDRESS_BITS = ptfa_pkg::DEF_ADDRESS_BITS
) (
	input  logic                                      go,
	input  logic [1:0]                                kind,
	input  logic                                      part_kind,
	input  logic [1:0]                                fit_mode,
	input  logic [ptfa_pkg::NAME_W-1:0]               name_tag,
	input  logic [ptfa_pkg::AMOUNT_W-1:0]             amount,
	input  logic [1:0]                                unit,
	input  logic [TABLE_SLOTS-1:0]                    mounted_mask,
	input  logic [TABLE_SLOTS-1:0]                    valid,
	input  logic [TABLE_SLOTS-1:0]                    ext,
	input  logic [ADDRESS_BITS-1:0]                   start [TABLE_SLOTS],
	input  logic [ADDRESS_BITS-1:0]                   size [TABLE_SLOTS],
	input  logic [ptfa_pkg::NAME_W-1:0]               name [TABLE_SLOTS],
	input  logic [ADDRESS_BITS-1:0]                   disk_size,
	input  logic [ptfa_pkg::FIRST_USABLE_W-1:0]       first_usable,
	output ptfa_pkg::tbl_op_t                         op,
	output ptfa_pkg::status_t                         status,
	output logic [ptfa_pkg::idx_w(TABLE_SLOTS)-1:0]   res_slot,
	output logic [ADDRESS_BITS-1:0]                   res_start,
	output logic [ADDRESS_BITS-1:0]                   res_size
);

	localparam int AW = ADDRESS_BITS;
	localparam int EW = ADDRESS_BITS + 1;
	localparam int DW = ptfa_pkg::DELTA_W;
	localparam int CW = (DW > EW) ? DW : EW;
	localparam int SW = ptfa_pkg::idx_w(TABLE_SLOTS);

	logic                     neg;
	logic [31:0]              mag;
	logic                     unit_bad;
	logic [DW-1:0]            bytes_full;
	logic [CW-1:0]            delta_cw;
	logic                     overflow;
	logic [AW-1:0]            need;
	logic [TABLE_SLOTS-1:0]   hit;
	logic [TABLE_SLOTS-1:0]   hit_first;
	logic [TABLE_SLOTS-1:0]   qual;
	logic [TABLE_SLOTS-1:0]   bwin;
	logic                     hit_seen;
	logic                     free_seen;
	logic [SW-1:0]            hit_idx;
	logic [SW-1:0]            free_idx;
	logic                     ext_exists;
	logic                     full;
	logic                     fit_found;
	logic [AW-1:0]            fit_start;
	logic [AW-1:0]            sel_start;
	logic [AW-1:0]            sel_size;
	logic                     sel_mounted;
	logic [EW-1:0]            part_end;
	logic [EW-1:0]            bound;
	logic [EW-1:0]            room;
	logic [CW-1:0]            size_cw;
	logic [CW-1:0]            new_cw;

	// magnitude and unit scaling
	always_comb begin
		neg      = amount[ptfa_pkg::AMOUNT_W-1];
		mag      = neg ? (~amount + 32'd1) : amount;
		unit_bad = 1'b0;
		case (unit)
			ptfa_pkg::UNIT_BYTES: bytes_full = DW'(mag);
			ptfa_pkg::UNIT_KIB:   bytes_full = DW'(mag) << ptfa_pkg::KIB_SHIFT;
			ptfa_pkg::UNIT_MIB:   bytes_full = DW'(mag) << ptfa_pkg::MIB_SHIFT;
			default: begin
				bytes_full = '0;
				unit_bad   = 1'b1;
			end
		endcase
		delta_cw = CW'(bytes_full);
		overflow = delta_cw > CW'({AW{1'b1}});
		need     = overflow ? {AW{1'b1}} : delta_cw[AW-1:0];
	end

	// name lookup, free slot and occupancy
	always_comb begin
		hit_seen   = 1'b0;
		free_seen  = 1'b0;
		hit_idx    = '0;
		free_idx   = '0;
		ext_exists = 1'b0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			hit[i]       = valid[i] && (name[i] == name_tag);
			hit_first[i] = hit[i] && !hit_seen;
			if (hit_first[i]) begin
				hit_idx = SW'(i);
			end
			hit_seen = hit_seen || hit[i];
			if (!valid[i] && !free_seen) begin
				free_idx = SW'(i);
			end
			free_seen  = free_seen || !valid[i];
			ext_exists = ext_exists || (valid[i] && ext[i]);
		end
		full = &valid;
	end

	// one-hot pick of the named entry
	always_comb begin
		sel_start   = '0;
		sel_size    = '0;
		sel_mounted = 1'b0;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			if (hit_first[i]) begin
				sel_start   = sel_start | start[i];
				sel_size    = sel_size | size[i];
				sel_mounted = sel_mounted | mounted_mask[i];
			end
		end
	end

	// grow bound: nearest mounted entry at or after the end, else disk end
	always_comb begin
		part_end = EW'(sel_start) + EW'(sel_size);
		for (int j = 0; j < TABLE_SLOTS; j++) begin
			qual[j] = valid[j] && !hit_first[j] && mounted_mask[j] &&
			          (EW'(start[j]) >= part_end) && (start[j] < disk_size);
		end
		bound = EW'(disk_size);
		for (int j = 0; j < TABLE_SLOTS; j++) begin
			bwin[j] = qual[j];
			for (int k = 0; k < TABLE_SLOTS; k++) begin
				if (k != j && qual[k]) begin
					bwin[j] = bwin[j] && (start[j] <= start[k]);
				end
			end
		end
		if (|bwin) begin
			bound = '0;
			for (int j = 0; j < TABLE_SLOTS; j++) begin
				if (bwin[j]) begin
					bound = bound | EW'(start[j]);
				end
			end
		end
		room = (bound > part_end) ? (bound - part_end) : '0;
	end

	ptfa_fit #(
		.TABLE_SLOTS  (TABLE_SLOTS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_fit (
		.valid        (valid),
		.start        (start),
		.size         (size),
		.disk_size    (disk_size),
		.first_usable (first_usable),
		.need         (need),
		.fit_mode     (fit_mode),
		.found        (fit_found),
		.pick_start   (fit_start)
	);

	// decision per request kind
	always_comb begin
		op        = '0;
		status    = ptfa_pkg::ST_OK;
		res_slot  = '0;
		res_start = '0;
		res_size  = '0;
		size_cw   = CW'(sel_size);
		new_cw    = size_cw;
		unique case (kind)
			ptfa_pkg::KIND_CREATE: begin
				if (amount == '0 || neg || unit_bad) begin
					status = ptfa_pkg::ST_BAD_SIZE;
				end else if (part_kind && ext_exists) begin
					status = ptfa_pkg::ST_EXT_EXISTS;
				end else if (full) begin
					status = ptfa_pkg::ST_FULL;
				end else if (hit_seen) begin
					status = ptfa_pkg::ST_DUP;
				end else if (overflow || !fit_found) begin
					status = ptfa_pkg::ST_NO_SPACE;
				end else begin
					op.create = go;
					res_slot  = free_idx;
					res_start = fit_start;
					res_size  = need;
				end
			end
			ptfa_pkg::KIND_DELETE: begin
				if (!hit_seen) begin
					status = ptfa_pkg::ST_NOT_FOUND;
				end else if (sel_mounted) begin
					status = ptfa_pkg::ST_MOUNTED;
				end else begin
					op.remove = go;
					res_slot  = hit_idx;
					res_start = sel_start;
				end
			end
			ptfa_pkg::KIND_RESIZE: begin
				if (unit_bad) begin
					status = ptfa_pkg::ST_BAD_SIZE;
				end else if (!hit_seen) begin
					status = ptfa_pkg::ST_NOT_FOUND;
				end else if (neg) begin
					if (delta_cw >= size_cw) begin
						status = ptfa_pkg::ST_SHRINK;
					end else begin
						new_cw = size_cw - delta_cw;
					end
				end else if (delta_cw == '0) begin
					if (sel_size == '0) begin
						status = ptfa_pkg::ST_SHRINK;
					end
				end else if (delta_cw > CW'(room)) begin
					status = ptfa_pkg::ST_NO_ROOM;
				end else begin
					new_cw = size_cw + delta_cw;
				end
				if (status == ptfa_pkg::ST_OK) begin
					op.resize = go;
					res_slot  = hit_idx;
					res_start = sel_start;
					res_size  = new_cw[AW-1:0];
				end
			end
			default: begin
				status = ptfa_pkg::ST_NOT_FOUND;
			end
		endcase
	end

endmodule

>>> rtl/partition_table_fit_allocator.sv
// top level of the partition table fit allocator: request register, table, result register
// depends on ptfa_pkg, ptfa_cfg, ptfa_table and ptfa_exec
//
// A request is taken on any clock edge with start high (busy is never raised). It is
// evaluated in the cycle after that edge and its result is registered on the next edge:
// the request is registered, evaluated against the partition table, and the result
// is registered together with the table update. done is high for exactly one cycle per
// request and the receiver cannot stall it, so results must be captured on that cycle.
// One request per cycle is sustained; each request sees every table change made by the
// one before it, since the table is written on the same edge that registers the result.
// The request and result registers enclose the evaluation (name lookup, gap walk in
// address order, fit contest, grow bound), which is the longest path. disk_size and
// first_usable are written over the apb port, 8 bytes apart; the user must write them
// only while no request is in flight, and the block itself does not enforce it.
module partition_table_fit_allocator #(
	parameter int TABLE_SLOTS  = ptfa_pkg::DEF_TABLE_SLOTS,
	parameter int ADDRESS_BITS = ptfa_pkg::DEF_ADDRESS_BITS
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// apb configuration port
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [ptfa_pkg::APB_ADDR_W-1:0]           paddr,
	input  logic [ptfa_pkg::APB_DATA_W-1:0]           pwdata,
	output logic [ptfa_pkg::APB_DATA_W-1:0]           prdata,
	output logic                                      pready,
	// request
	input  logic                                      start,
	output logic                                      busy,
	input  logic [1:0]                                kind,
	input  logic                                      part_kind,
	input  logic [1:0]                                fit_mode,
	input  logic [ptfa_pkg::NAME_W-1:0]               name_tag,
	input  logic signed [ptfa_pkg::AMOUNT_W-1:0]      amount,
	input  logic [1:0]                                unit,
	input  logic [TABLE_SLOTS-1:0]                    mounted_mask,
	// result
	output logic                                      done,
	output logic [3:0]                                status,
	output logic [ptfa_pkg::idx_w(TABLE_SLOTS)-1:0]   slot,
	output logic [ADDRESS_BITS-1:0]                   slot_start,
	output logic [ADDRESS_BITS-1:0]                   slot_size
);

	localparam int SW = ptfa_pkg::idx_w(TABLE_SLOTS);

	// configuration
	logic [ADDRESS_BITS-1:0]             disk_size;
	logic [ptfa_pkg::FIRST_USABLE_W-1:0] first_usable;

	// request register
	logic                                valid_s1;
	logic [1:0]                          kind_s1;
	logic                                part_kind_s1;
	logic [1:0]                          fit_mode_s1;
	logic [ptfa_pkg::NAME_W-1:0]         name_tag_s1;
	logic [ptfa_pkg::AMOUNT_W-1:0]       amount_s1;
	logic [1:0]                          unit_s1;
	logic [TABLE_SLOTS-1:0]              mounted_s1;

	// table view
	logic [TABLE_SLOTS-1:0]              tbl_valid;
	logic [TABLE_SLOTS-1:0]              tbl_ext;
	logic [ADDRESS_BITS-1:0]             tbl_start [TABLE_SLOTS];
	logic [ADDRESS_BITS-1:0]             tbl_size [TABLE_SLOTS];
	logic [ptfa_pkg::NAME_W-1:0]         tbl_name [TABLE_SLOTS];

	// evaluation outputs
	ptfa_pkg::tbl_op_t                   op;
	ptfa_pkg::status_t                   ex_status;
	logic [SW-1:0]                       ex_slot;
	logic [ADDRESS_BITS-1:0]             ex_start;
	logic [ADDRESS_BITS-1:0]             ex_size;

	// result register
	logic                                done_s2;
	ptfa_pkg::status_t                   status_s2;
	logic [SW-1:0]                       slot_s2;
	logic [ADDRESS_BITS-1:0]             start_s2;
	logic [ADDRESS_BITS-1:0]             size_s2;

	// the table keeps up with one request per cycle, so never busy
	assign busy = 1'b0;

	ptfa_cfg #(
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.disk_size    (disk_size),
		.first_usable (first_usable)
	);

	// request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1      <= kind;
			part_kind_s1 <= part_kind;
			fit_mode_s1  <= fit_mode;
			name_tag_s1  <= name_tag;
			amount_s1    <= amount;
			unit_s1      <= unit;
			mounted_s1   <= mounted_mask;
		end
	end

	// partition table, written on the edge that registers the result
	ptfa_table #(
		.TABLE_SLOTS  (TABLE_SLOTS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.wr_slot  (ex_slot),
		.wr_ext   (part_kind_s1),
		.wr_start (ex_start),
		.wr_size  (ex_size),
		.wr_name  (name_tag_s1),
		.valid    (tbl_valid),
		.ext      (tbl_ext),
		.start    (tbl_start),
		.size     (tbl_size),
		.name     (tbl_name)
	);

	// combinational evaluation of the registered request
	ptfa_exec #(
		.TABLE_SLOTS  (TABLE_SLOTS),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_exec (
		.go           (valid_s1),
		.kind         (kind_s1),
		.part_kind    (part_kind_s1),
		.fit_mode     (fit_mode_s1),
		.name_tag     (name_tag_s1),
		.amount       (amount_s1),
		.unit         (unit_s1),
		.mounted_mask (mounted_s1),
		.valid        (tbl_valid),
		.ext          (tbl_ext),
		.start        (tbl_start),
		.size         (tbl_size),
		.name         (tbl_name),
		.disk_size    (disk_size),
		.first_usable (first_usable),
		.op           (op),
		.status       (ex_status),
		.res_slot     (ex_slot),
		.res_start    (ex_start),
		.res_size     (ex_size)
	);

	// result strobe and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= ex_status;
			slot_s2   <= ex_slot;
			start_s2  <= ex_start;
			size_s2   <= ex_size;
		end
	end

	assign done       = done_s2;
	assign status     = status_s2;
	assign slot       = slot_s2;
	assign slot_start = start_s2;
	assign slot_size  = size_s2;

endmodule
